@@ src/cell_motion_integrator_top_defines.svh @@
// Assertion macros used by the block's top-level RTL file.
`ifndef CELL_MOTION_INTEGRATOR_TOP_DEFINES_SVH
`define CELL_MOTION_INTEGRATOR_TOP_DEFINES_SVH

// The antecedent holds at a clock edge, so the consequent holds at the same edge.
`define CMI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds at a clock edge, so the consequent holds at the next edge.
`define CMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cmi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cmi_pkg;

    localparam int DW = 32;
    localparam int FW = 16;
    localparam int PW = 2 * DW;
    localparam int UW = DW - 1;
    // Restoring division of 2^(2*FW) by a magnitude of at least three: the two
    // leading dividend bits leave a partial remainder of two, the rest give the quotient.
    localparam int QW = DW - 1;
    localparam int RW = DW + 1;

    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PW-1:0] FX_ONE = PW'(1) << FW;

    typedef enum logic [2:0] {
        REG_WALL_EN   = 3'd0,
        REG_WALL_STR  = 3'd1,
        REG_EXTENT_X  = 3'd2,
        REG_EXTENT_Y  = 3'd3,
        REG_EXTENT_Z  = 3'd4,
        REG_TIME_STEP = 3'd5,
        REG_DRAG      = 3'd6,
        REG_NOISE_SC  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]           axis;
        logic signed [DW-1:0] position;
        logic signed [DW-1:0] velocity;
        logic signed [DW-1:0] force_in;
        logic signed [DW-1:0] gradient;
        logic signed [DW-1:0] noise;
        logic [UW-1:0]        radius;
        logic [UW-1:0]        sigma;
        logic signed [DW-1:0] transduction;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           axis_out;
        logic signed [DW-1:0] new_position;
        logic signed [DW-1:0] new_velocity;
        logic signed [DW-1:0] new_force;
    } t_out_item;

    typedef struct packed {
        logic [RW-1:0] rem_u;
        logic [QW-1:0] q_u;
        logic [RW-1:0] rem_r;
        logic [QW-1:0] q_r;
    } t_lane;

    typedef struct packed {
        logic [1:0]           axis;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] f;
        logic signed [DW-1:0] grad;
        logic signed [DW-1:0] nz;
        logic [UW-1:0]        r;
        logic [UW-1:0]        sg;
        logic signed [DW-1:0] td;
        logic [UW-1:0]        ext;
        logic                 wall_lo;
        logic                 wall_hi;
        logic                 neg_u;
        logic [DW-1:0]        mag_u;
        logic signed [PW-1:0] p_td;
        logic signed [PW-1:0] p_sn;
        logic signed [PW-1:0] p_tv;
        logic signed [PW-1:0] p_dr;
        logic signed [DW-1:0] tg;
        logic signed [DW-1:0] sns;
        logic signed [DW-1:0] nx;
        logic signed [DW-1:0] damp;
        logic signed [PW-1:0] p_nz;
        logic signed [PW-1:0] p_vd;
        logic signed [DW-1:0] noise_f;
        logic signed [DW-1:0] vd;
        logic signed [DW-1:0] t;
        logic signed [PW-1:0] p_w;
        logic signed [PW-1:0] p_tf;
        logic signed [DW-1:0] nv;
    } t_pipe;

    function automatic logic signed [PW-1:0] sx(input logic signed [DW-1:0] a);
        return {{(PW-DW){a[DW-1]}}, a};
    endfunction

    function automatic logic signed [DW-1:0] fx_sat(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] res;
        if (v > sx(SAT_MAX)) begin
            res = SAT_MAX;
        end else if (v < sx(SAT_MIN)) begin
            res = SAT_MIN;
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    // An arithmetic shift rounds toward minus infinity, as the format asks.
    function automatic logic signed [DW-1:0] fx_norm(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p >>> FW;
        return fx_sat(s);
    endfunction

endpackage
`default_nettype wire

@@ src/cell_motion_integrator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------
// input     | i_valid / o_stall  | i_in  (cmi_pkg::t_in_item)
// result    | o_valid / i_stall  | o_out (cmi_pkg::t_out_item)
// config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One item enters per cycle while o_stall is low.
// The depth is set by the two bit-per-stage reciprocal dividers (31 stages).
// Synchronous active-low reset clears the valid bits and the configuration registers.
// A stalled result freezes only the unbroken run of full stages behind it; bubbles close up.
`include "cell_motion_integrator_top_defines.svh"
module cell_motion_integrator_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire cmi_pkg::t_in_item   i_in,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output cmi_pkg::t_out_item       o_out,
    input  wire logic                i_cfg_we,
    input  wire cmi_pkg::t_reg_idx   i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data
);
    import cmi_pkg::*;

    localparam int ST_IN    = 0;
    localparam int ST_MUL1  = 1;
    localparam int ST_NORM1 = 2;
    localparam int ST_MUL2  = 3;
    localparam int ST_NORM2 = 4;
    localparam int ST_DIV0  = 5;
    localparam int DIV_N    = QW;
    localparam int ST_RECIP = ST_DIV0 + DIV_N;
    localparam int ST_WMUL  = ST_RECIP + 1;
    localparam int ST_FORCE = ST_WMUL + 1;
    localparam int ST_NOISE = ST_FORCE + 1;
    localparam int ST_TMUL  = ST_NOISE + 1;
    localparam int ST_OUT   = ST_TMUL + 1;
    localparam int N_ST     = ST_OUT + 1;

    logic                 r_wall_en;
    logic signed [DW-1:0] r_wall_str;
    logic [UW-1:0]        r_ext_x;
    logic [UW-1:0]        r_ext_y;
    logic [UW-1:0]        r_ext_z;
    logic [UW-1:0]        r_dt;
    logic [UW-1:0]        r_drag;
    logic [UW-1:0]        r_noise_sc;

    logic [N_ST-1:0]      r_v;
    t_pipe                r_d [N_ST];
    t_pipe                n_d [N_ST];
    logic [N_ST-1:0]      w_en;
    t_lane                w_lane [DIV_N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_en  <= 1'b0;
            r_wall_str <= '0;
            r_ext_x    <= '0;
            r_ext_y    <= '0;
            r_ext_z    <= '0;
            r_dt       <= '0;
            r_drag     <= '0;
            r_noise_sc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WALL_EN:   r_wall_en  <= i_cfg_data[0];
                REG_WALL_STR:  r_wall_str <= i_cfg_data;
                REG_EXTENT_X:  r_ext_x    <= i_cfg_data[UW-1:0];
                REG_EXTENT_Y:  r_ext_y    <= i_cfg_data[UW-1:0];
                REG_EXTENT_Z:  r_ext_z    <= i_cfg_data[UW-1:0];
                REG_TIME_STEP: r_dt       <= i_cfg_data[UW-1:0];
                REG_DRAG:      r_drag     <= i_cfg_data[UW-1:0];
                REG_NOISE_SC:  r_noise_sc <= i_cfg_data[UW-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[N_ST-1] = !r_v[N_ST-1] || !i_stall;
        for (int k = N_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[ST_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_ST; k++) begin
            if (w_en[k]) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    always_comb begin
        w_lane[0]       = '0;
        w_lane[0].rem_u = RW'(2);
        w_lane[0].rem_r = RW'(2);
    end

    genvar g;
    generate
        for (g = 0; g < N_ST; g++) begin : g_st
            if (g == ST_IN) begin : g_in
                always_comb begin
                    n_d[g]      = '0;
                    n_d[g].axis = i_in.axis;
                    n_d[g].x    = i_in.position;
                    n_d[g].v    = i_in.velocity;
                    n_d[g].f    = i_in.force_in;
                    n_d[g].grad = i_in.gradient;
                    n_d[g].nz   = i_in.noise;
                    n_d[g].r    = i_in.radius;
                    n_d[g].sg   = i_in.sigma;
                    n_d[g].td   = i_in.transduction;
                    case (i_in.axis)
                        2'd0:    n_d[g].ext = r_ext_x;
                        2'd1:    n_d[g].ext = r_ext_y;
                        default: n_d[g].ext = r_ext_z;
                    endcase
                end
            end else if (g == ST_MUL1) begin : g_mul1
                logic signed [DW+1:0] x34;
                logic signed [DW+1:0] r34;
                logic signed [DW+1:0] d34;
                logic signed [DW+1:0] u34;
                logic signed [DW+1:0] a34;
                logic                 lo;
                logic signed [DW-1:0] sg_s;
                logic signed [DW-1:0] ns_s;
                logic signed [DW-1:0] dt_s;
                logic signed [DW-1:0] dr_s;
                always_comb begin
                    n_d[g] = r_d[g-1];
                    x34  = {{2{r_d[g-1].x[DW-1]}}, r_d[g-1].x};
                    r34  = {3'b000, r_d[g-1].r};
                    d34  = {3'b000, r_d[g-1].ext} - x34;
                    lo   = r_wall_en && (x34 < r34) && (x34 != '0);
                    u34  = lo ? x34 : d34;
                    a34  = u34[DW+1] ? -u34 : u34;
                    sg_s = {1'b0, r_d[g-1].sg};
                    ns_s = {1'b0, r_noise_sc};
                    dt_s = {1'b0, r_dt};
                    dr_s = {1'b0, r_drag};
                    n_d[g].wall_lo = lo;
                    n_d[g].wall_hi = r_wall_en && !lo && (d34 < r34) && (d34 != '0);
                    n_d[g].neg_u   = u34[DW+1];
                    n_d[g].mag_u   = a34[DW-1:0];
                    n_d[g].p_td    = r_d[g-1].td * r_d[g-1].grad;
                    n_d[g].p_sn    = sg_s * ns_s;
                    n_d[g].p_tv    = dt_s * r_d[g-1].v;
                    n_d[g].p_dr    = dt_s * dr_s;
                end
            end else if (g == ST_NORM1) begin : g_norm1
                always_comb begin
                    n_d[g]      = r_d[g-1];
                    n_d[g].tg   = fx_norm(r_d[g-1].p_td);
                    n_d[g].sns  = fx_norm(r_d[g-1].p_sn);
                    n_d[g].nx   = fx_sat(sx(r_d[g-1].x) + sx(fx_norm(r_d[g-1].p_tv)));
                    n_d[g].damp = fx_sat(FX_ONE - sx(fx_norm(r_d[g-1].p_dr)));
                end
            end else if (g == ST_MUL2) begin : g_mul2
                always_comb begin
                    n_d[g]      = r_d[g-1];
                    n_d[g].p_nz = r_d[g-1].sns * r_d[g-1].nz;
                    n_d[g].p_vd = r_d[g-1].v * r_d[g-1].damp;
                end
            end else if (g == ST_NORM2) begin : g_norm2
                always_comb begin
                    n_d[g]         = r_d[g-1];
                    n_d[g].noise_f = fx_norm(r_d[g-1].p_nz);
                    n_d[g].vd      = fx_norm(r_d[g-1].p_vd);
                end
            end else if (g < ST_RECIP) begin : g_div
                always_comb begin
                    n_d[g] = r_d[g-1];
                end
                cmi_div_stage u_div (
                    .i_clk   (i_clk),
                    .i_en    (w_en[g]),
                    .i_lane  (w_lane[g-ST_DIV0]),
                    .i_mag_u (r_d[g-1].mag_u),
                    .i_mag_r (r_d[g-1].r),
                    .o_lane  (w_lane[g-ST_DIV0+1])
                );
            end else if (g == ST_RECIP) begin : g_recip
                logic signed [DW-1:0] qu;
                logic signed [DW-1:0] qr;
                logic signed [DW-1:0] ru;
                always_comb begin
                    n_d[g] = r_d[g-1];
                    // A magnitude of zero, one or two gives a reciprocal beyond range.
                    qu = (r_d[g-1].mag_u <= DW'(2)) ? SAT_MAX : {1'b0, w_lane[DIV_N].q_u};
                    qr = (r_d[g-1].r <= UW'(2)) ? SAT_MAX : {1'b0, w_lane[DIV_N].q_r};
                    ru = r_d[g-1].neg_u ? -qu : qu;
                    n_d[g].t = fx_sat(sx(ru) - sx(qr));
                end
            end else if (g == ST_WMUL) begin : g_wmul
                always_comb begin
                    n_d[g]     = r_d[g-1];
                    n_d[g].p_w = r_wall_str * r_d[g-1].t;
                end
            end else if (g == ST_FORCE) begin : g_force
                logic signed [DW-1:0] w;
                logic signed [DW-1:0] f1;
                always_comb begin
                    n_d[g] = r_d[g-1];
                    w = fx_norm(r_d[g-1].p_w);
                    if (r_d[g-1].wall_lo) begin
                        f1 = fx_sat(sx(r_d[g-1].f) + sx(w));
                    end else if (r_d[g-1].wall_hi) begin
                        f1 = fx_sat(sx(r_d[g-1].f) - sx(w));
                    end else begin
                        f1 = r_d[g-1].f;
                    end
                    n_d[g].f = fx_sat(sx(f1) + sx(r_d[g-1].tg));
                end
            end else if (g == ST_NOISE) begin : g_noise
                always_comb begin
                    n_d[g]   = r_d[g-1];
                    n_d[g].f = fx_sat(sx(r_d[g-1].f) + sx(r_d[g-1].noise_f));
                end
            end else if (g == ST_TMUL) begin : g_tmul
                logic signed [DW-1:0] dt_s;
                always_comb begin
                    n_d[g]      = r_d[g-1];
                    dt_s        = {1'b0, r_dt};
                    n_d[g].p_tf = dt_s * r_d[g-1].f;
                end
            end else begin : g_out
                always_comb begin
                    n_d[g]    = r_d[g-1];
                    n_d[g].nv = fx_sat(sx(r_d[g-1].vd) + sx(fx_norm(r_d[g-1].p_tf)));
                end
            end
        end
    endgenerate

    assign o_valid            = r_v[ST_OUT];
    assign o_out.axis_out     = r_d[ST_OUT].axis;
    assign o_out.new_position = r_d[ST_OUT].nx;
    assign o_out.new_velocity = r_d[ST_OUT].nv;
    assign o_out.new_force    = r_d[ST_OUT].f;

    `CMI_ASSERT_SAME(a_stall_source, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a stalled result")
    `CMI_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall, r_v[ST_IN], "accepted item missing from the first stage")
    `CMI_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, r_v[ST_RECIP-1] && !w_en[ST_RECIP-1], r_v[ST_RECIP-1], "stalled divider stage lost its item")
endmodule
`default_nettype wire

@@ src/cmi_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cmi_div_stage (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire cmi_pkg::t_lane  i_lane,
    input  wire logic [31:0]     i_mag_u,
    input  wire logic [30:0]     i_mag_r,
    output cmi_pkg::t_lane       o_lane
);
    import cmi_pkg::*;

    cmi_pkg::t_lane r_lane;
    cmi_pkg::t_lane n_lane;
    logic [RW-1:0]  w_sh_u;
    logic [RW-1:0]  w_sh_r;
    logic [RW-1:0]  w_dv_u;
    logic [RW-1:0]  w_dv_r;

    // One quotient bit per lane; the remaining dividend bits are all zero.
    always_comb begin
        w_sh_u = {i_lane.rem_u[RW-2:0], 1'b0};
        w_sh_r = {i_lane.rem_r[RW-2:0], 1'b0};
        w_dv_u = {1'b0, i_mag_u};
        w_dv_r = {2'b00, i_mag_r};
        n_lane = i_lane;
        if (w_sh_u >= w_dv_u) begin
            n_lane.rem_u = w_sh_u - w_dv_u;
            n_lane.q_u   = {i_lane.q_u[QW-2:0], 1'b1};
        end else begin
            n_lane.rem_u = w_sh_u;
            n_lane.q_u   = {i_lane.q_u[QW-2:0], 1'b0};
        end
        if (w_sh_r >= w_dv_r) begin
            n_lane.rem_r = w_sh_r - w_dv_r;
            n_lane.q_r   = {i_lane.q_r[QW-2:0], 1'b1};
        end else begin
            n_lane.rem_r = w_sh_r;
            n_lane.q_r   = {i_lane.q_r[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire
